>>> hdl/three_band_equalizer_top_defines.svh
// ---------------------------------------------------------------------------
// three band equalizer assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef THREE_BAND_EQUALIZER_TOP_DEFINES_SVH
`define THREE_BAND_EQUALIZER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define TBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tbe check failed");

// next-cycle implication checked outside reset
`define TBE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tbe check failed");

`endif

>>> hdl/tbe_pkg.sv
// ---------------------------------------------------------------------------
// tbe_pkg
// shared constants and types of the three band equalizer
// ---------------------------------------------------------------------------
package tbe_pkg;

  localparam int unsigned CfgRegs = 5;
  localparam int unsigned CoefBits = 18;
  localparam int unsigned GainBits = 16;
  localparam int unsigned PoleBits = 32;
  localparam int unsigned PolesPerCh = 4;
  localparam int unsigned HistDepth = 3;
  localparam int unsigned AccBits = 64;
  localparam int unsigned PAddrBits = 5;

  // register byte addresses
  localparam logic [PAddrBits-1:0] AddrLowCoef = 5'd0;
  localparam logic [PAddrBits-1:0] AddrHighCoef = 5'd4;
  localparam logic [PAddrBits-1:0] AddrLowGain = 5'd8;
  localparam logic [PAddrBits-1:0] AddrMidGain = 5'd12;
  localparam logic [PAddrBits-1:0] AddrHighGain = 5'd16;

  localparam logic [CoefBits-1:0] LowCoefRst = 18'd27305;
  localparam logic [CoefBits-1:0] HighCoefRst = 18'd166560;
  localparam logic [GainBits-1:0] GainRst = 16'd4096;

  // serial multiplier request
  typedef struct packed {
    logic              start;
    logic signed [AccBits-1:0] mcand;
    logic [CoefBits-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic signed [AccBits-1:0] prod;
  } mul_rsp_t;

endpackage

>>> hdl/tbe_serial_mul.sv
// ---------------------------------------------------------------------------
// tbe_serial_mul
// shift-add multiplier, one bit of the unsigned multiplier per cycle
// ---------------------------------------------------------------------------
module tbe_serial_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbe_pkg::mul_req_t  req_i,
  output tbe_pkg::mul_rsp_t  rsp_o
);

  localparam int unsigned CntBits = $clog2(tbe_pkg::CoefBits + 1);

  logic signed [tbe_pkg::AccBits-1:0] acc_q, acc_d;
  logic signed [tbe_pkg::AccBits-1:0] mc_q, mc_d;
  logic [tbe_pkg::CoefBits-1:0] mp_q, mp_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;

  // one partial product per cycle, lsb first
  always_comb begin
    acc_d = acc_q;
    mc_d = mc_q;
    mp_d = mp_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d = '0;
      mc_d = req_i.mcand;
      mp_d = req_i.mplier;
      cnt_d = CntBits'(tbe_pkg::CoefBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d = mc_q <<< 1;
      mp_d = mp_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q <= mc_d;
    mp_q <= mp_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

>>> hdl/three_band_equalizer_top.sv
// ---------------------------------------------------------------------------
// three_band_equalizer_top
// eight channel three band equalizer with one shared serial multiplier
// ---------------------------------------------------------------------------
// usage: a word on s_axis carries channel (tdata low bits) and sample.
// each word yields one word on m_axis with the channel and the equalized,
// saturated sample. the user must write the registers over the apb port
// only while idle; the block itself does not enforce this.
// an in-range word runs eight pole updates and three gain products through
// one shift-add multiplier, each as a start, one step per multiplier bit and
// a done, then passes a saturate state and an output state.
// an out-of-range channel passes through: it goes straight from idle to the
// output state and does not use the multiplier.
// the next word is taken once the result sits in the output register, even
// while the receiver stalls; a stalled result holds until taken, and a newer
// result waits in the output state until the register is free.
// reset clears all poles and history at once (valid bits per channel) and
// loads the register defaults; the block is ready right after reset.
// ---------------------------------------------------------------------------
module three_band_equalizer_top #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel [2:0], sample_in [SAMPLE_BITS+2:3], zero padded
  input  logic [((SAMPLE_BITS+3+7)/8)*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // channel_out [2:0], sample_out [SAMPLE_BITS+2:3], zero padded
  output logic [((SAMPLE_BITS+3+7)/8)*8-1:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [tbe_pkg::PAddrBits-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DataBits = ((SAMPLE_BITS + 3 + 7) / 8) * 8;
  localparam int unsigned ChBits = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned Up = 32 - SAMPLE_BITS;
  localparam int unsigned Shr = 44 - SAMPLE_BITS;
  localparam int unsigned AB = tbe_pkg::AccBits;
  localparam int unsigned PB = tbe_pkg::PoleBits;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StPole = 7'b0000010,
    StPoleW = 7'b0000100,
    StGain = 7'b0001000,
    StGainW = 7'b0010000,
    StSat = 7'b0100000,
    StOut = 7'b1000000
  } state_e;

  // configuration registers
  logic [tbe_pkg::CoefBits-1:0] low_coef_q, high_coef_q;
  logic [tbe_pkg::GainBits-1:0] low_gain_q, mid_gain_q, high_gain_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_coef_q <= tbe_pkg::LowCoefRst;
      high_coef_q <= tbe_pkg::HighCoefRst;
      low_gain_q <= tbe_pkg::GainRst;
      mid_gain_q <= tbe_pkg::GainRst;
      high_gain_q <= tbe_pkg::GainRst;
    end else if (wr_en) begin
      unique case (paddr)
        tbe_pkg::AddrLowCoef:  low_coef_q <= pwdata[tbe_pkg::CoefBits-1:0];
        tbe_pkg::AddrHighCoef: high_coef_q <= pwdata[tbe_pkg::CoefBits-1:0];
        tbe_pkg::AddrLowGain:  low_gain_q <= pwdata[tbe_pkg::GainBits-1:0];
        tbe_pkg::AddrMidGain:  mid_gain_q <= pwdata[tbe_pkg::GainBits-1:0];
        tbe_pkg::AddrHighGain: high_gain_q <= pwdata[tbe_pkg::GainBits-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr)
      tbe_pkg::AddrLowCoef:  prdata = 32'(low_coef_q);
      tbe_pkg::AddrHighCoef: prdata = 32'(high_coef_q);
      tbe_pkg::AddrLowGain:  prdata = 32'(low_gain_q);
      tbe_pkg::AddrMidGain:  prdata = 32'(mid_gain_q);
      tbe_pkg::AddrHighGain: prdata = 32'(high_gain_q);
      default:               prdata = '0;
    endcase
  end

  // per channel state with valid bits
  logic signed [PB-1:0] lp_q [CHANNELS][tbe_pkg::PolesPerCh];
  logic signed [PB-1:0] hp_q [CHANNELS][tbe_pkg::PolesPerCh];
  logic signed [SAMPLE_BITS-1:0] hist_q [CHANNELS][tbe_pkg::HistDepth];
  logic [CHANNELS-1:0] vld_q;

  state_e st_q, st_d;
  logic [ChBits-1:0] ch_q;
  logic [2:0] chin_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [2:0] step_q;   // pole index 0..7: low 0..3, high 4..7, gain 0..2
  logic signed [PB-1:0] x_q;
  logic signed [PB-1:0] p_cur;
  logic signed [PB-1:0] lo_q, hc_q;
  logic signed [AB-1:0] sum_q;
  logic out_vld_q;
  logic [2:0] out_ch_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q;
  tbe_pkg::mul_req_t mreq;
  tbe_pkg::mul_rsp_t mrsp;
  logic in_acc, ch_ok, out_load;
  logic signed [AB-1:0] d3, hb, mb, band, newp, shifted;
  logic signed [PB-1:0] newp_sat;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == StIdle);
  assign ch_ok = 32'(s_axis_tdata[2:0]) < CHANNELS;
  // result moves to the output register once that register is free
  assign out_load = (st_q == StOut) && (!out_vld_q || m_axis_tready);

  tbe_serial_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  // current pole of the channel, reset value if channel not yet valid
  always_comb begin
    if (!vld_q[ch_q]) begin
      p_cur = '0;
    end else if (step_q[2]) begin
      p_cur = hp_q[ch_q][step_q[1:0]];
    end else begin
      p_cur = lp_q[ch_q][step_q[1:0]];
    end
  end

  // band forming
  always_comb begin
    d3 = vld_q[ch_q] ? (AB'(hist_q[ch_q][2]) <<< Up) : '0;
    hb = d3 - AB'(hc_q);
    mb = d3 - (hb + AB'(lo_q));
    unique case (step_q[1:0])
      2'd0:    band = AB'(lo_q);
      2'd1:    band = mb;
      default: band = hb;
    endcase
  end

  // multiplier request
  always_comb begin
    mreq.start = (st_q == StPole) || (st_q == StGain);
    mreq.mcand = (st_q == StPole) ? (AB'(x_q) - AB'(p_cur)) : band;
    if (st_q == StPole) begin
      mreq.mplier = step_q[2] ? high_coef_q : low_coef_q;
    end else begin
      unique case (step_q[1:0])
        2'd0:    mreq.mplier = tbe_pkg::CoefBits'(low_gain_q);
        2'd1:    mreq.mplier = tbe_pkg::CoefBits'(mid_gain_q);
        default: mreq.mplier = tbe_pkg::CoefBits'(high_gain_q);
      endcase
    end
  end

  // pole result with floor shift and saturation
  always_comb begin
    newp = AB'(p_cur) + (mrsp.prod >>> 16);
    if (newp > AB'(64'sh7fffffff)) begin
      newp_sat = {1'b0, {(PB-1){1'b1}}};
    end else if (newp < -AB'(64'sh80000000)) begin
      newp_sat = {1'b1, {(PB-1){1'b0}}};
    end else begin
      newp_sat = newp[PB-1:0];
    end
    shifted = sum_q >>> Shr;
    if (shifted > AB'((64'sd1 <<< (SAMPLE_BITS-1)) - 1)) begin
      sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (shifted < -AB'(64'sd1 <<< (SAMPLE_BITS-1))) begin
      sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_val = shifted[SAMPLE_BITS-1:0];
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (in_acc) st_d = ch_ok ? StPole : StOut;
      StPole:  st_d = StPoleW;
      StPoleW: if (mrsp.done) st_d = (step_q == 3'd7) ? StGain : StPole;
      StGain:  st_d = StGainW;
      StGainW: if (mrsp.done) st_d = (step_q == 3'd2) ? StSat : StGain;
      StSat:   st_d = StOut;
      StOut:   if (out_load) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      vld_q <= '0;
      out_vld_q <= 1'b0;
      step_q <= '0;
    end else begin
      st_q <= st_d;
      // output valid: set on load, cleared when taken
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: step_q <= '0;
        StPoleW: if (mrsp.done) step_q <= (step_q == 3'd7) ? 3'd0 : step_q + 3'd1;
        StGainW: if (mrsp.done) step_q <= step_q + 3'd1;
        StSat: vld_q[ch_q] <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chin_q <= s_axis_tdata[2:0];
      ch_q <= ChBits'(s_axis_tdata[2:0]);
      smp_q <= s_axis_tdata[SAMPLE_BITS+2:3];
      x_q <= PB'(s_axis_tdata[SAMPLE_BITS+2:3]) <<< Up;
      sum_q <= '0;
    end
    if (st_q == StPoleW && mrsp.done) begin
      if (step_q == 3'd3) begin
        lo_q <= newp_sat;
        x_q <= PB'(smp_q) <<< Up;
      end else begin
        x_q <= newp_sat;
      end
      if (step_q == 3'd7) hc_q <= newp_sat;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < tbe_pkg::PolesPerCh; k++) begin
          if (ChBits'(c) == ch_q && 2'(k) == step_q[1:0]) begin
            if (step_q[2]) hp_q[c][k] <= newp_sat;
            else lp_q[c][k] <= newp_sat;
          end else if (ChBits'(c) == ch_q && !vld_q[c]) begin
            if (step_q[2] || step_q[1:0] > 2'(k)) begin
              if (!step_q[2]) lp_q[c][k] <= lp_q[c][k];
            end
          end
        end
      end
    end
    // first touch of a channel: zero the untouched poles
    if (st_q == StPole && step_q == 3'd0 && !vld_q[ch_q]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (ChBits'(c) == ch_q) begin
          for (int k = 0; k < tbe_pkg::PolesPerCh; k++) begin
            lp_q[c][k] <= '0;
            hp_q[c][k] <= '0;
          end
          for (int k = 0; k < tbe_pkg::HistDepth; k++) hist_q[c][k] <= '0;
        end
      end
    end
    if (st_q == StGainW && mrsp.done) sum_q <= sum_q + mrsp.prod;
    // history shift; the saturated sum replaces the sample
    if (st_q == StSat) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (ChBits'(c) == ch_q) begin
          hist_q[c][2] <= vld_q[c] ? hist_q[c][1] : '0;
          hist_q[c][1] <= vld_q[c] ? hist_q[c][0] : '0;
          hist_q[c][0] <= smp_q;
        end
      end
      smp_q <= sat_val;
    end
    if (out_load) begin
      out_ch_q <= chin_q;
      out_smp_q <= smp_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = DataBits'({out_smp_q, out_ch_q});

endmodule

>>> hdl/tbe_checker.sv
// ---------------------------------------------------------------------------
// tbe_checker
// port-level checks of the equalizer, bound to the top level
// ---------------------------------------------------------------------------
`include "three_band_equalizer_top_defines.svh"

module tbe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic pready
);

  // a taken word leaves the block busy next cycle
  `TBE_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a stalled result stays valid
  `TBE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // config port never waits
  `TBE_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)

endmodule

bind three_band_equalizer_top tbe_checker u_tbe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .pready       (pready)
);
